[design/emv_pkg.sv]
// Shared types and constants for the multi-turn encoder unwrapper and velocity estimator.
package emv_pkg;

  // configuration register file
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_US      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ELAPSED_US = 2'd2;

  localparam int unsigned WRAP_THR_W = 14;
  localparam int unsigned WINDOW_W   = 20;
  localparam int unsigned MAX_ELAP_W = 24;

  localparam logic [WRAP_THR_W-1:0] WRAP_THR_RST = 14'd13107;
  localparam logic [WINDOW_W-1:0]   WINDOW_RST   = 20'd1000;
  localparam logic [MAX_ELAP_W-1:0] MAX_ELAP_RST = 24'd100000;

  // fixed-width result fields
  localparam int unsigned TURN_W = 32;
  localparam int unsigned VEL_W  = 32;

  localparam logic [VEL_W-1:0] VEL_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0] VEL_NEG_SAT = 32'h8000_0000;

  // scaling multiply: 44-bit magnitude in two 22-bit halves times 10^6
  localparam int unsigned MUL_IN_W   = 44;
  localparam int unsigned MUL_HALF_W = 22;
  localparam int unsigned US_PER_S_W = 20;
  localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;
  localparam int unsigned PROD_W     = MUL_HALF_W + US_PER_S_W;
  localparam int unsigned NUM_W      = 64;

  // restoring divider: 32 quotient bits, divisor below 2^24
  localparam int unsigned QUO_W      = 32;
  localparam int unsigned DIVISOR_W  = 24;
  localparam int unsigned DIV_CNT_W  = 5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EVAL,
    ST_MAG,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_INIT,
    ST_DIV,
    ST_FINISH,
    ST_DONE
  } emv_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic eval;
    logic mag;
    logic mul_lo;
    logic mul_hi;
    logic sum;
    logic div_init;
    logic div_step;
    logic finish;
    logic load_out;
  } emv_cmd_t;

  typedef struct packed {
    logic restart;
    logic window_hit;
    logic out_free;
  } emv_status_t;

endpackage

[design/emv_ctrl.sv]
// Sequencer for the unwrap, scaling and division steps of one transaction.
module emv_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  emv_pkg::emv_status_t sts_i,
  output emv_pkg::emv_cmd_t    cmd_o
);
  import emv_pkg::*;

  emv_state_e             state_q, state_d;
  logic [DIV_CNT_W-1:0]   cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.restart ? ST_DONE : ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.window_hit ? ST_MAG : ST_DONE;
      end
      ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

[design/emv_dp.sv]
// Datapath: config registers, turn tracking, velocity scaling and divider, result buffer.
module emv_dp #(
  parameter int unsigned ANGLE_BITS = 14,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // register writes
  input  logic                              cfg_we_i,
  input  logic [emv_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [emv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // input item
  input  logic                              action_i,
  input  logic [ANGLE_BITS-1:0]             raw_angle_i,
  input  logic [TIME_BITS-1:0]              timestamp_us_i,
  // sequencing
  input  emv_pkg::emv_cmd_t                 cmd_i,
  output emv_pkg::emv_status_t              sts_o,
  // result buffer
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic [emv_pkg::TURN_W-1:0]        rotation_count_o,
  output logic [ANGLE_BITS-1:0]             lap_angle_o,
  output logic [emv_pkg::TURN_W+ANGLE_BITS-1:0] full_position_o,
  output logic [emv_pkg::VEL_W-1:0]         velocity_o,
  output logic                              velocity_fresh_o
);
  import emv_pkg::*;

  localparam int unsigned A      = ANGLE_BITS;
  localparam int unsigned POS_W  = TURN_W + A;
  localparam int unsigned DPOS_W = POS_W + 1;
  localparam int unsigned MAG_W  = POS_W;
  localparam int unsigned MAGX_W = (MAG_W > MUL_IN_W) ? MAG_W : MUL_IN_W + 1;
  localparam int unsigned THR_W  = (A > WRAP_THR_W) ? A : WRAP_THR_W;
  localparam int unsigned CMP_W  = (TIME_BITS > MAX_ELAP_W) ? TIME_BITS : MAX_ELAP_W;

  // configuration
  logic [WRAP_THR_W-1:0] thr_q;
  logic [WINDOW_W-1:0]   win_q;
  logic [MAX_ELAP_W-1:0] max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= WRAP_THR_RST;
      win_q <= WINDOW_RST;
      max_q <= MAX_ELAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WRAP_THRESHOLD: thr_q <= cfg_data_i[WRAP_THR_W-1:0];
        REG_WINDOW_US:      win_q <= cfg_data_i[WINDOW_W-1:0];
        REG_MAX_ELAPSED_US: max_q <= cfg_data_i[MAX_ELAP_W-1:0];
        default: ;
      endcase
    end
  end

  // architectural state
  logic [A-1:0]         prev_q, ref_angle_q;
  logic [TURN_W-1:0]    turn_q, ref_turns_q;
  logic [TIME_BITS-1:0] ref_time_q;
  logic [VEL_W-1:0]     held_q;
  logic                 fresh_q;

  // per-transaction working registers
  logic                 action_q;
  logic [A-1:0]         angle_q;
  logic [TIME_BITS-1:0] ts_q, elapsed_q;
  logic                 zero_q, neg_q, big_q, ovf_q;
  logic signed [DPOS_W-1:0] dpos_q;
  logic [MUL_IN_W-1:0]  mag_q;
  logic [PROD_W-1:0]    prod_lo_q, prod_hi_q;
  logic [NUM_W-1:0]     num_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [QUO_W-1:0]     quo_q;

  // result buffer
  logic                 out_valid_q;
  logic [TURN_W-1:0]    out_rot_q;
  logic [A-1:0]         out_lap_q;
  logic [POS_W-1:0]     out_pos_q;
  logic [VEL_W-1:0]     out_vel_q;
  logic                 out_fresh_q;

  // wrap detection
  logic signed [A:0]    dlt;
  logic [A:0]           dlt_abs;
  logic                 wrap;
  logic [TURN_W-1:0]    turn_d;

  always_comb begin
    dlt     = $signed({1'b0, angle_q}) - $signed({1'b0, prev_q});
    dlt_abs = dlt[A] ? -dlt : dlt;
    wrap    = THR_W'(dlt_abs[A-1:0]) > THR_W'(thr_q);
    turn_d  = turn_q;
    if (wrap) begin
      // forward jump means a backward wrap past zero
      turn_d = dlt[A] ? turn_q + 1'b1 : turn_q - 1'b1;
    end
  end

  // elapsed time checks
  logic [CMP_W-1:0]     elapsed_x;
  logic [DIVISOR_W-1:0] divisor;
  assign elapsed_x = CMP_W'(elapsed_q);
  assign divisor   = elapsed_x[DIVISOR_W-1:0];

  // position moved since the reference
  logic signed [TURN_W-1:0] dturns;
  logic signed [A:0]        dang;
  logic signed [DPOS_W-1:0] dpos_d;
  always_comb begin
    dturns = $signed(turn_q - ref_turns_q);
    dang   = $signed({1'b0, prev_q}) - $signed({1'b0, ref_angle_q});
    dpos_d = (DPOS_W'(dturns) <<< A) + DPOS_W'(dang);
  end

  logic [DPOS_W-1:0] dpos_abs;
  logic [MAGX_W-1:0] mag_x;
  assign dpos_abs = dpos_q[DPOS_W-1] ? 0 - dpos_q : dpos_q;
  assign mag_x    = MAGX_W'(dpos_abs[MAG_W-1:0]);

  // one shared 22x20 multiplier
  logic [MUL_HALF_W-1:0] mul_a;
  logic [PROD_W-1:0]     prod;
  assign mul_a = cmd_i.mul_lo ? mag_q[MUL_HALF_W-1:0] : mag_q[MUL_IN_W-1:MUL_HALF_W];
  assign prod  = PROD_W'(mul_a) * PROD_W'(US_PER_S);

  // one restoring division step
  logic [DIVISOR_W:0]   trial;
  logic                 trial_ge;
  assign trial    = {rem_q, quo_q[QUO_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  logic [VEL_W-1:0] vel_new;
  always_comb begin
    if (zero_q) begin
      vel_new = '0;
    end else if (ovf_q || big_q || quo_q[QUO_W-1]) begin
      vel_new = neg_q ? VEL_NEG_SAT : VEL_POS_SAT;
    end else begin
      vel_new = neg_q ? 0 - quo_q : quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      ref_angle_q <= '0;
      turn_q      <= '0;
      ref_turns_q <= '0;
      ref_time_q  <= '0;
      held_q      <= '0;
      fresh_q     <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        fresh_q <= 1'b0;
      end
      if (cmd_i.update) begin
        prev_q <= angle_q;
        if (action_q) begin
          ref_angle_q <= angle_q;
          ref_time_q  <= ts_q;
          ref_turns_q <= turn_q;
          held_q      <= '0;
        end else begin
          turn_q <= turn_d;
        end
      end
      if (cmd_i.finish) begin
        held_q      <= vel_new;
        ref_angle_q <= prev_q;
        ref_turns_q <= turn_q;
        ref_time_q  <= ts_q;
        fresh_q     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      angle_q  <= raw_angle_i;
      ts_q     <= timestamp_us_i;
    end
    if (cmd_i.update) begin
      elapsed_q <= ts_q - ref_time_q;
    end
    if (cmd_i.eval) begin
      dpos_q <= dpos_d;
      zero_q <= (elapsed_x == '0) || (elapsed_x > CMP_W'(max_q));
    end
    if (cmd_i.mag) begin
      neg_q <= dpos_q[DPOS_W-1];
      big_q <= |mag_x[MAGX_W-1:MUL_IN_W];
      mag_q <= mag_x[MUL_IN_W-1:0];
    end
    if (cmd_i.mul_lo) begin
      prod_lo_q <= prod;
    end
    if (cmd_i.mul_hi) begin
      prod_hi_q <= prod;
    end
    if (cmd_i.sum) begin
      num_q <= (NUM_W'(prod_hi_q) << MUL_HALF_W) + NUM_W'(prod_lo_q);
    end
    if (cmd_i.div_init) begin
      // quotient of 2^32 or more saturates in any case
      ovf_q <= num_q[NUM_W-1:QUO_W] >= QUO_W'(divisor);
      rem_q <= num_q[QUO_W+DIVISOR_W-1:QUO_W];
      quo_q <= num_q[QUO_W-1:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? DIVISOR_W'(trial - {1'b0, divisor}) : trial[DIVISOR_W-1:0];
      quo_q <= {quo_q[QUO_W-2:0], trial_ge};
    end
  end

  // result buffer: frees the sequencer while the consumer stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_rot_q   <= turn_q;
      out_lap_q   <= prev_q;
      out_pos_q   <= {turn_q, prev_q};
      out_vel_q   <= held_q;
      out_fresh_q <= fresh_q;
    end
  end

  assign sts_o.restart    = action_q;
  assign sts_o.window_hit = elapsed_x >= CMP_W'(win_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign rotation_count_o = out_rot_q;
  assign lap_angle_o      = out_lap_q;
  assign full_position_o  = out_pos_q;
  assign velocity_o       = out_vel_q;
  assign velocity_fresh_o = out_fresh_q;

endmodule

[design/encoder_multiturn_velocity.sv]
// Top level: multi-turn encoder unwrapping with windowed velocity estimation.
//
//  channel  dir  handshake                     payload
//  -------  ---  ----------------------------  -----------------------------------------
//  s_axis   in   s_axis_tvalid/s_axis_tready   tdata: raw_angle, timestamp_us; tuser: action
//  m_axis   out  m_axis_tvalid/m_axis_tready   tdata: rotation_count, lap_angle,
//                                              full_position, velocity; tuser: velocity_fresh
//  cfg      in   cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One transaction in at a time. A restart item passes through the update step only,
// an item inside the velocity window through update and window check, and an item that
// recomputes velocity through all steps: the 32-step restoring divider (one quotient bit
// per cycle) dominates, behind two passes through the shared 22x20 scaling multiplier.
// A one-entry result buffer lets the next item in while a result waits on m_axis;
// a stalled consumer only holds the sequencer once a second result is ready.
// Reset (async, active low) clears turn count, references and held velocity and
// loads the register defaults. The cfg channel is always ready.
module encoder_multiturn_velocity #(
  parameter int unsigned ANGLE_BITS = 14,
  parameter int unsigned TIME_BITS  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [ANGLE_BITS-1:0] raw_angle, then timestamp_us, zero fill to whole bytes
  input  logic [((ANGLE_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // [0] action: 0 sample, 1 restart references
  input  logic [0:0]                    s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // rotation_count (32), lap_angle, full_position (32+ANGLE_BITS), velocity (32),
  // zero fill to whole bytes
  output logic [((3*32+2*ANGLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // [0] velocity_fresh
  output logic [0:0]                    m_axis_tuser,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [emv_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [emv_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import emv_pkg::*;

  localparam int unsigned OUT_DW = ((3*32 + 2*ANGLE_BITS + 7) / 8) * 8;
  localparam int unsigned POS_W  = TURN_W + ANGLE_BITS;

  emv_cmd_t    cmd;
  emv_status_t sts;

  logic [TURN_W-1:0]     rotation_count;
  logic [ANGLE_BITS-1:0] lap_angle;
  logic [POS_W-1:0]      full_position;
  logic [VEL_W-1:0]      velocity;
  logic                  velocity_fresh;

  assign cfg_ready_o = 1'b1;

  emv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  emv_dp #(
    .ANGLE_BITS (ANGLE_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .action_i         (s_axis_tuser[0]),
    .raw_angle_i      (s_axis_tdata[ANGLE_BITS-1:0]),
    .timestamp_us_i   (s_axis_tdata[ANGLE_BITS+TIME_BITS-1:ANGLE_BITS]),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .rotation_count_o (rotation_count),
    .lap_angle_o      (lap_angle),
    .full_position_o  (full_position),
    .velocity_o       (velocity),
    .velocity_fresh_o (velocity_fresh)
  );

  assign m_axis_tdata = OUT_DW'({velocity, full_position, lap_angle, rotation_count});
  assign m_axis_tuser = velocity_fresh;

endmodule

[dv/encoder_multiturn_velocity_test.sv]
// Self-checking testbench for the multi-turn encoder unwrapper and velocity estimator.
module encoder_multiturn_velocity_test;
  import emv_pkg::*;

  localparam int unsigned ANGLE_W  = 14;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned IN_W     = ((ANGLE_W + STAMP_W + 7) / 8) * 8;
  localparam int unsigned OUT_W    = ((3 * 32 + 2 * ANGLE_W + 7) / 8) * 8;
  localparam int unsigned POS_W    = TURN_W + ANGLE_W;

  // tuser codes on the input side
  localparam logic ACT_SAMPLE  = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // index past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int unsigned STALL_LIMIT = 4000;  // cycles without any transaction
  localparam int unsigned DRAIN_WAIT  = 60;    // covers the recompute path
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 204;

  typedef struct {
    logic [TURN_W-1:0]  turns;
    logic [ANGLE_W-1:0] lap;
    logic [POS_W-1:0]   position;
    logic [VEL_W-1:0]   rate;
    logic               fresh;
  } encoder_reading_t;

  // Holds a private copy of the unwrapper state and registers, works out the reading
  // each accepted sample must produce and compares the readings that come back.
  class velocity_scoreboard;
    logic [WRAP_THR_W-1:0] wrap_limit;
    logic [WINDOW_W-1:0]   window_len;
    logic [MAX_ELAP_W-1:0] max_elapsed;

    logic [ANGLE_W-1:0] last_angle;
    logic [TURN_W-1:0]  turns;
    logic [ANGLE_W-1:0] anchor_angle;
    logic [TURN_W-1:0]  anchor_turns;
    logic [STAMP_W-1:0] anchor_stamp;
    logic [VEL_W-1:0]   rate_hold;

    encoder_reading_t expected_readings[$];
    int unsigned      failures;

    function new();
      wrap_limit   = WRAP_THR_RST;
      window_len   = WINDOW_RST;
      max_elapsed  = MAX_ELAP_RST;
      last_angle   = '0;
      turns        = '0;
      anchor_angle = '0;
      anchor_turns = '0;
      anchor_stamp = '0;
      rate_hold    = '0;
      failures     = 0;
    endfunction

    function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_WRAP_THRESHOLD: wrap_limit  = data[WRAP_THR_W-1:0];
        REG_WINDOW_US:      window_len  = data[WINDOW_W-1:0];
        REG_MAX_ELAPSED_US: max_elapsed = data[MAX_ELAP_W-1:0];
        default: ;
      endcase
    endfunction

    // counts per second since the anchor, truncated toward zero and saturated
    function logic [VEL_W-1:0] rate_since_anchor(logic [STAMP_W-1:0] elapsed);
      logic [TURN_W-1:0] turn_diff;
      longint            dturns;
      longint            pa;
      longint            ra;
      longint            dpos;
      longint unsigned   mag;
      longint unsigned   quot;
      logic [31:0]       q32;
      logic              neg;
      turn_diff = turns - anchor_turns;
      dturns = $signed(turn_diff);
      pa = last_angle;
      ra = anchor_angle;
      dpos = dturns * (64'sd1 <<< ANGLE_W) + (pa - ra);
      neg = dpos < 0;
      mag = neg ? -dpos : dpos;
      if (elapsed == 0 || elapsed > max_elapsed) return '0;
      if (mag >= (64'd1 << 44)) quot = 64'd1 << 32;
      else quot = (mag * 64'd1000000) / elapsed;
      q32 = quot[31:0];
      if (neg) return (quot >= 64'h8000_0000) ? VEL_NEG_SAT : -q32;
      return (quot > 64'h7FFF_FFFF) ? VEL_POS_SAT : q32;
    endfunction

    function void note_sample(logic act, logic [ANGLE_W-1:0] ang, logic [STAMP_W-1:0] ts);
      encoder_reading_t rd;
      logic [STAMP_W-1:0] elapsed;
      int a_new;
      int a_old;
      int delta;
      int span;
      int limit;
      rd.fresh = 1'b0;
      if (act == ACT_RESTART) begin
        last_angle   = ang;
        anchor_angle = ang;
        anchor_stamp = ts;
        anchor_turns = turns;
        rate_hold    = '0;
      end else begin
        a_new = ang;
        a_old = last_angle;
        limit = wrap_limit;
        delta = a_new - a_old;
        span = (delta < 0) ? -delta : delta;
        // forward jump over the limit is a wrap backwards through zero, and vice versa
        if (span > limit) turns = turns + ((delta > 0) ? 32'hFFFF_FFFF : 32'd1);
        last_angle = ang;
        elapsed = ts - anchor_stamp;
        if (elapsed >= window_len) begin
          rate_hold    = rate_since_anchor(elapsed);
          anchor_angle = last_angle;
          anchor_turns = turns;
          anchor_stamp = ts;
          rd.fresh     = 1'b1;
        end
      end
      rd.turns    = turns;
      rd.lap      = last_angle;
      rd.position = {turns, last_angle};  // turns * 2^14 + angle, angle below 2^14
      rd.rate     = rate_hold;
      expected_readings.push_back(rd);
    endfunction

    function void check_result(encoder_reading_t got);
      encoder_reading_t want;
      if (expected_readings.size() == 0) begin
        $display("%0t: reading with nothing outstanding: turns %h lap %h pos %h rate %h fresh %b",
                 $time, got.turns, got.lap, got.position, got.rate, got.fresh);
        failures++;
        return;
      end
      want = expected_readings.pop_front();
      if (got.turns !== want.turns) begin
        $display("%0t: rotation_count expected %h actual %h", $time, want.turns, got.turns);
        failures++;
      end
      if (got.lap !== want.lap) begin
        $display("%0t: lap_angle expected %h actual %h", $time, want.lap, got.lap);
        failures++;
      end
      if (got.position !== want.position) begin
        $display("%0t: full_position expected %h actual %h", $time, want.position,
                 got.position);
        failures++;
      end
      if (got.rate !== want.rate) begin
        $display("%0t: velocity expected %h actual %h", $time, want.rate, got.rate);
        failures++;
      end
      if (got.fresh !== want.fresh) begin
        $display("%0t: velocity_fresh expected %b actual %b", $time, want.fresh, got.fresh);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_W-1:0]       s_axis_tdata  = '0;
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_W-1:0]      m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  velocity_scoreboard sb = new();

  // the last phase runs with both sides at full rate
  logic calm = 1'b0;

  // where the synthetic shaft currently is; random motion steps from here
  logic [ANGLE_W-1:0] shaft_angle = '0;
  logic [STAMP_W-1:0] shaft_stamp = '0;

  encoder_multiturn_velocity #(
    .ANGLE_BITS(ANGLE_W),
    .TIME_BITS (STAMP_W)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: every accepted transaction is unpacked and checked.
  // Values read right after the edge are the ones the block saw at that edge.
  always @(posedge clk_i) begin
    encoder_reading_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.turns    = m_axis_tdata[TURN_W-1:0];
      got.lap      = m_axis_tdata[TURN_W +: ANGLE_W];
      got.position = m_axis_tdata[TURN_W + ANGLE_W +: POS_W];
      got.rate     = m_axis_tdata[TURN_W + ANGLE_W + POS_W +: VEL_W];
      got.fresh    = m_axis_tuser[0];
      sb.check_result(got);
    end
  end

  // Consumer back-pressure: random stall bursts between runs of ready.
  int unsigned ready_left = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        ready_left = $urandom_range(1, 13);
      end else begin
        m_axis_tready <= 1'b1;
        ready_left = $urandom_range(1, 30);
      end
    end else begin
      ready_left--;
    end
  end

  // Watchdog: the run is hung once no transaction has moved for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("encoder_multiturn_velocity_test: errors");
        $finish;
      end
    end
  end

  // Presents one sample and waits for its transaction; returns on the accepting edge
  // with tvalid still high, so the caller either follows on or drops it.
  task automatic send_sample(logic act, logic [ANGLE_W-1:0] ang, logic [STAMP_W-1:0] ts);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - ANGLE_W - STAMP_W){1'b0}}, ts, ang};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_sample(act, ang, ts);
  endtask

  // Sample with an occasional producer gap ahead of it.
  task automatic feed(logic act, logic [ANGLE_W-1:0] ang, logic [STAMP_W-1:0] ts);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    send_sample(act, ang, ts);
    shaft_angle = ang;
    shaft_stamp = ts;
  endtask

  // Registers only change with the block idle: every reading back, and the
  // recompute path given time to settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.apply_setting(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random settings per phase, extremes weighted in. Upper data bits are random so
  // the masking to register width is exercised too.
  task automatic pick_settings();
    logic [WRAP_THR_W-1:0] thr;
    logic [WINDOW_W-1:0]   win;
    logic [MAX_ELAP_W-1:0] lim;
    case ($urandom_range(0, 4))
      0:       thr = '0;
      1:       thr = '1;
      2:       thr = WRAP_THR_RST;
      default: thr = WRAP_THR_W'($urandom_range(1000, 16000));
    endcase
    case ($urandom_range(0, 6))
      0:       win = '0;
      1:       win = 20'd1;
      2:       win = 20'd1000000;
      3:       win = '1;
      default: win = WINDOW_W'($urandom_range(2, 5000));
    endcase
    case ($urandom_range(0, 5))
      0:       lim = '0;
      1:       lim = 24'd1;
      2:       lim = '1;
      3:       lim = 24'd10000000;
      default: lim = MAX_ELAP_W'($urandom_range(10, 200000));
    endcase
    program_register(REG_WRAP_THRESHOLD, {10'($urandom), thr});
    program_register(REG_WINDOW_US, {4'($urandom), win});
    program_register(REG_MAX_ELAPSED_US, lim);
    if ($urandom_range(0, 1) == 0) program_register(REG_SPARE, 24'($urandom));
  endtask

  // Mostly smooth motion with wraps and time steps around the window; some restarts
  // and some samples with unrelated angle and stamp.
  task automatic motion_item();
    int unsigned      pick;
    int               reach;
    int               step;
    longint unsigned  dt;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      feed(ACT_RESTART, ($urandom_range(0, 1) == 0) ? shaft_angle : 14'($urandom),
           shaft_stamp + $urandom_range(0, 3000));
    end else if (pick < 15) begin
      feed(ACT_SAMPLE, 14'($urandom), $urandom);
    end else begin
      case ($urandom_range(0, 3))
        0:       reach = 64;
        1:       reach = 2000;
        2:       reach = 6000;
        default: reach = 16383;
      endcase
      step = int'($urandom_range(0, 2 * reach)) - reach;
      if ($urandom_range(0, 9) == 0) dt = sb.max_elapsed + $urandom_range(1, 1000);
      else dt = $urandom_range(0, 2 * sb.window_len + 2);
      feed(ACT_SAMPLE, shaft_angle + 14'(step), shaft_stamp + 32'(dt));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, register defaults first: wraps both ways, the threshold edge,
    // holding inside the window, elapsed too long and the stamp wrapping round.
    feed(ACT_SAMPLE,  14'd0,     32'd0);
    feed(ACT_RESTART, 14'd16383, 32'd500);
    feed(ACT_SAMPLE,  14'd0,     32'd600);
    feed(ACT_SAMPLE,  14'd16383, 32'd1600);
    feed(ACT_SAMPLE,  14'd100,   32'd2600);
    feed(ACT_SAMPLE,  14'd13207, 32'd2700);
    feed(ACT_SAMPLE,  14'd99,    32'd3700);
    feed(ACT_SAMPLE,  14'd200,   32'hFFFF_FFF0);
    feed(ACT_SAMPLE,  14'd300,   32'h0000_0400);
    feed(ACT_SAMPLE,  14'd16383, 32'hFFFF_FFFF);

    // one-microsecond window, widest limit, no wraps: saturation both ways
    drain();
    program_register(REG_WINDOW_US, 24'hF0_0001);
    program_register(REG_MAX_ELAPSED_US, 24'hFF_FFFF);
    program_register(REG_WRAP_THRESHOLD, 24'hFF_FFFF);
    feed(ACT_RESTART, 14'd0,     32'd100);
    feed(ACT_SAMPLE,  14'd8000,  32'd101);
    feed(ACT_SAMPLE,  14'd0,     32'd102);
    feed(ACT_SAMPLE,  14'd16383, 32'd103);
    feed(ACT_SAMPLE,  14'd5,     32'd1103);

    // zero window: zero elapsed gives zero; zero threshold makes any move a wrap
    drain();
    program_register(REG_WINDOW_US, 24'hF0_0000);
    program_register(REG_WRAP_THRESHOLD, 24'h00_0000);
    program_register(REG_MAX_ELAPSED_US, 24'h00_0001);
    program_register(REG_SPARE, 24'h00_0007);
    feed(ACT_SAMPLE,  14'd5,     32'd1103);
    feed(ACT_SAMPLE,  14'd6,     32'd1104);
    feed(ACT_SAMPLE,  14'd6,     32'd1106);
    feed(ACT_RESTART, 14'd7,     32'd5000);
    feed(ACT_SAMPLE,  14'd7,     32'd5000);

    // Random part, one register setting per phase; the last phase runs flat out.
    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      drain();
      pick_settings();
      if (ph == PHASES - 1) calm = 1'b1;
      repeat (PHASE_ITEMS) motion_item();
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("encoder_multiturn_velocity_test: clean");
    end else begin
      $display("encoder_multiturn_velocity_test: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
design/emv_pkg.sv
design/emv_ctrl.sv
design/emv_dp.sv
design/encoder_multiturn_velocity.sv
dv/encoder_multiturn_velocity_test.sv
